### design/bsuc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bsuc_pkg;

  localparam int unsigned WORD_BITS      = 64;
  localparam int unsigned BIT_IDX_W      = 6;
  localparam int unsigned POS_W          = 16;
  localparam int unsigned POS_WORD_W     = POS_W - BIT_IDX_W;
  localparam int unsigned END_W          = 17;
  localparam int unsigned COUNT_W        = 17;
  localparam int unsigned KIND_W         = 2;
  localparam int unsigned WORD_COUNT_DEF = 1024;

  localparam logic [KIND_W-1:0] KIND_SET   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RANGE = 2'd2;

endpackage

`default_nettype wire

### design/bsuc_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bsuc_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### design/bitset_update_with_count.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Signals                                               Transfer
// -------   ----------------------------------------------------  ---------------------
// item in   kind, position, range_end, first_of_list, count_in    start high, busy low
// result    count                                                 done high, one cycle
//
// Set-bit and clear-bit items read the addressed word in the accept cycle, then
// write it back in S_BIT, after which done pulses while busy is low.
// A range fill reads each word touched in S_FILL_RD, then ORs and writes it in S_FILL_WR,
// on the single RAM port pair; an empty range passes through S_BIT with no write.
// After reset, busy stays high while every word is zeroed.
// The receiver cannot stall: each count is shown for exactly one cycle with done.

module bitset_update_with_count
  import bsuc_pkg::*;
#(
  parameter int unsigned WORD_COUNT = WORD_COUNT_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [KIND_W-1:0]  kind,
  input  wire logic [POS_W-1:0]   position,
  input  wire logic [END_W-1:0]   range_end,
  input  wire logic               first_of_list,
  input  wire logic [COUNT_W-1:0] count_in,
  output logic                    done,
  output logic [COUNT_W-1:0]      count
);

  localparam int unsigned AW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam logic [END_W-1:0] LIMIT = END_W'(WORD_COUNT * WORD_BITS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(WORD_COUNT - 1);
  localparam logic [POS_WORD_W:0] WORD_COUNT_C = (POS_WORD_W + 1)'(WORD_COUNT);
  localparam logic [BIT_IDX_W-1:0] TOP_BIT = BIT_IDX_W'(WORD_BITS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_BIT,
    S_FILL_RD,
    S_FILL_WR
  } state_t;

  state_t               state;
  logic [AW-1:0]        clr_addr;
  logic [AW-1:0]        cur;
  logic [AW-1:0]        last_word;
  logic [BIT_IDX_W-1:0] lo_first;
  logic [BIT_IDX_W-1:0] hi_last;
  logic                 at_first;
  logic [BIT_IDX_W-1:0] bit_idx;
  logic                 op_set;
  logic                 bit_en;
  logic [COUNT_W-1:0]   cnt;

  logic                  accept;
  logic [POS_WORD_W-1:0] pos_word;
  logic                  word_ok;
  logic [END_W-1:0]      end_c;
  logic [END_W-1:0]      end_m1;
  logic [POS_WORD_W-1:0] end_word;
  logic                  range_empty;
  logic [COUNT_W-1:0]    cnt_base;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  logic [WORD_BITS-1:0] bit_mask;
  logic                 old_bit;
  logic [BIT_IDX_W-1:0] lo_cur;
  logic [BIT_IDX_W-1:0] hi_cur;
  logic [WORD_BITS-1:0] fill_mask;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign count  = cnt;

  assign pos_word    = position[POS_W-1:BIT_IDX_W];
  assign word_ok     = ({1'b0, pos_word} < WORD_COUNT_C);
  assign end_c       = (range_end > LIMIT) ? LIMIT : range_end;
  assign range_empty = (end_c <= {1'b0, position});
  assign end_m1      = end_c - END_W'(1);
  assign end_word    = end_m1[POS_W-1:BIT_IDX_W];
  assign cnt_base    = first_of_list ? count_in : cnt;

  assign bit_mask = WORD_BITS'(1) << bit_idx;
  assign old_bit  = ram_rdata[bit_idx];

  // Span of the current word: from the start offset on the first word, up to the
  // end offset on the last word.
  assign lo_cur    = at_first ? lo_first : '0;
  assign hi_cur    = (cur == last_word) ? hi_last : TOP_BIT;
  assign fill_mask = ({WORD_BITS{1'b1}} << lo_cur) & ({WORD_BITS{1'b1}} >> (TOP_BIT - hi_cur));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur;
    ram_wdata = ram_rdata | fill_mask;
    ram_raddr = pos_word[AW-1:0];
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      S_BIT: begin
        ram_we    = bit_en;
        ram_waddr = cur;
        ram_wdata = op_set ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);
      end
      S_FILL_RD: begin
        ram_raddr = cur;
      end
      S_FILL_WR: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      cnt      <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          if (clr_addr == LAST_ADDR) begin
            state <= S_IDLE;
          end else begin
            clr_addr <= clr_addr + AW'(1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            cnt       <= cnt_base;
            cur       <= pos_word[AW-1:0];
            last_word <= end_word[AW-1:0];
            lo_first  <= position[BIT_IDX_W-1:0];
            hi_last   <= end_m1[BIT_IDX_W-1:0];
            at_first  <= 1'b1;
            bit_idx   <= position[BIT_IDX_W-1:0];
            op_set    <= (kind == KIND_SET);
            bit_en    <= ((kind == KIND_SET) || (kind == KIND_CLEAR)) && word_ok;
            if ((kind == KIND_RANGE) && !range_empty) begin
              state <= S_FILL_RD;
            end else begin
              state <= S_BIT;
            end
          end
        end
        S_BIT: begin
          // adjust the count only when the addressed bit actually flips
          if (bit_en && op_set && !old_bit) begin
            cnt <= cnt + COUNT_W'(1);
          end else if (bit_en && !op_set && old_bit) begin
            cnt <= cnt - COUNT_W'(1);
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_FILL_RD: begin
          state <= S_FILL_WR;
        end
        S_FILL_WR: begin
          at_first <= 1'b0;
          if (cur == last_word) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            cur   <= cur + AW'(1);
            state <= S_FILL_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  bsuc_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(WORD_COUNT)
  ) u_words (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

endmodule

`default_nettype wire
